// ----- hw/rtl/sts_pkg.sv -----
// Shared types and command/result codes for the timer slot scheduler.
// No dependencies.
`timescale 1ns / 1ps
package sts_pkg;
  localparam logic [2:0] CMD_TICK    = 3'd0;
  localparam logic [2:0] CMD_SERVICE = 3'd1;
  localparam logic [2:0] CMD_ADD     = 3'd2;
  localparam logic [2:0] CMD_DELETE  = 3'd3;
  localparam logic [2:0] CMD_QUERY   = 3'd4;

  localparam logic [2:0] KIND_FIRED   = 3'd0;
  localparam logic [2:0] KIND_SERVICE = 3'd1;
  localparam logic [2:0] KIND_ADD     = 3'd2;
  localparam logic [2:0] KIND_DELETE  = 3'd3;
  localparam logic [2:0] KIND_QUERY   = 3'd4;
  localparam logic [2:0] KIND_TICK    = 3'd5;

  localparam logic [31:0] MAX_SLEEP_RESET = 32'd60000;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  task_key;
    logic [30:0] delay_ms;
    logic [30:0] reload_ms;
    logic [15:0] elapsed_ms;
  } req_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  key_out;
    logic        ok;
    logic [31:0] next_wake_ms;
    logic        last;
  } rsp_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction
endpackage

// ----- hw/rtl/sts_if.sv -----
// Valid/ready channel interfaces for requests and results.
// Depends on sts_pkg.
`timescale 1ns / 1ps
interface sts_req_if;
  logic           valid;
  logic           ready;
  sts_pkg::req_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface sts_rsp_if;
  logic           valid;
  logic           ready;
  sts_pkg::rsp_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/software_timer_slot_scheduler_top.sv -----
// Top level of the timer slot scheduler: slot table, list walk sequencer.
// Depends on sts_pkg and sts_if.
//
//   channel  | dir | handshake     | payload
//   req      | in  | valid/ready   | cmd, task_key, delay_ms, reload_ms, elapsed_ms
//   rsp      | out | valid/ready   | kind, key_out, ok, next_wake_ms, last
//   cfg      | in  | cfg_we        | max_sleep_ms (cfg_wdata)
//
// One request is taken at a time; req.ready stays low until its last result is
// taken. Add, delete and query first scan all SLOTS slots through a shared compare.
// Service walks the list one entry per cycle through the shared subtract/compare
// unit, but a due entry waits for a free result register, and a dropped slot
// stops the walk while the later entries move up. A service with no wake pending
// does not walk the list. Reset (rst, synchronous) empties the table.
// A stalled result holds the walk.
`timescale 1ns / 1ps
module software_timer_slot_scheduler_top #(
  parameter int SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  sts_req_if.sink     req,
  sts_rsp_if.source   rsp
);
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_FIND = 6'b000010,
    ST_EXEC = 6'b000100,
    ST_WALK = 6'b001000,
    ST_SHFT = 6'b010000,
    ST_OUT  = 6'b100000
  } state_t;

  state_t state;
  sts_pkg::req_t r;

  logic [31:0] max_sleep;
  logic        used [SLOTS];
  logic [7:0]  skey [SLOTS];
  logic [31:0] sdly [SLOTS];
  logic [31:0] srld [SLOTS];
  logic        skil [SLOTS];
  logic [IW-1:0] order [SLOTS];
  logic [CW-1:0] len;
  logic        wake_pending, wake_early;
  logic [31:0] sleep_length, sleep_left, missed_time, best;

  logic [CW-1:0] idx;      // search / walk position
  logic [CW-1:0] sh;       // list shift position
  logic          found;
  logic [IW-1:0] fslot;
  logic          ran;

  // result holding register
  logic          ov;
  sts_pkg::rsp_t ob;
  assign rsp.valid   = ov;
  assign rsp.payload = ob;
  wire out_free = !ov || rsp.ready;

  assign req.ready = (state == ST_IDLE) && !ov;

  // shared unit: compare and subtract on the current walk slot
  logic [IW-1:0] ws;
  logic [31:0]   wd;
  logic          due;
  logic [31:0]   diff;
  assign ws   = order[idx[IW-1:0]];
  assign wd   = sdly[ws];
  assign due  = wd <= sleep_length;
  assign diff = wd - sleep_length;

  // free slot search (priority, narrow)
  logic          has_free;
  logic [IW-1:0] free_slot;
  always_comb begin
    has_free  = 1'b0;
    free_slot = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        has_free  = 1'b1;
        free_slot = IW'(i);
      end
    end
  end

  logic [31:0] cd;
  assign cd = sts_pkg::sat_add({16'd0, r.elapsed_ms}, missed_time);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      ov           <= 1'b0;
      max_sleep    <= sts_pkg::MAX_SLEEP_RESET;
      len          <= '0;
      wake_pending <= 1'b1;
      wake_early   <= 1'b0;
      sleep_length <= '0;
      sleep_left   <= '0;
      missed_time  <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        used[i] <= 1'b0; skey[i] <= '0; sdly[i] <= '0; srld[i] <= '0; skil[i] <= 1'b0;
      end
    end else begin
      if (cfg_we) max_sleep <= cfg_wdata;
      // drop a taken result unless the walk loads the register in this cycle
      if (ov && rsp.ready && !(state == ST_WALK && (idx >= len || due))) ov <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (req.valid && req.ready) begin
            r     <= req.payload;
            idx   <= '0;
            found <= 1'b0;
            fslot <= '0;
            case (req.payload.cmd)
              sts_pkg::CMD_TICK, sts_pkg::CMD_SERVICE: state <= ST_EXEC;
              sts_pkg::CMD_ADD, sts_pkg::CMD_DELETE, sts_pkg::CMD_QUERY: state <= ST_FIND;
              default: state <= ST_IDLE;
            endcase
          end
        end
        // scan the table for the key, one slot per cycle
        ST_FIND: begin
          if (!found && used[idx[IW-1:0]] && skey[idx[IW-1:0]] == r.task_key) begin
            found <= 1'b1;
            fslot <= idx[IW-1:0];
          end
          if (idx == CW'(SLOTS - 1)) state <= ST_EXEC;
          else idx <= idx + 1'b1;
        end
        ST_EXEC: begin
          ob.next_wake_ms <= (r.cmd == sts_pkg::CMD_SERVICE) ? sleep_length : '0;
          ob.key_out      <= r.task_key;
          ob.last         <= 1'b1;
          case (r.cmd)
            sts_pkg::CMD_TICK: begin
              logic wp, we;
              logic [31:0] sl, sn;
              wp = wake_pending; we = wake_early; sl = sleep_left; sn = sleep_length;
              if (!wake_pending) begin
                if (sleep_length != 0) begin
                  if (sleep_left > cd) sl = sleep_left - cd;
                  else begin sl = '0; wp = 1'b1; we = 1'b0; end
                  if (we) begin sn = sleep_length - sl; sl = '0; wp = 1'b1; we = 1'b0; end
                end
                missed_time <= '0;
              end else begin
                missed_time <= cd;
              end
              wake_pending <= wp; wake_early <= we; sleep_left <= sl; sleep_length <= sn;
              ob.kind <= sts_pkg::KIND_TICK; ob.ok <= wp;
              ov <= 1'b1; state <= ST_OUT;
            end
            sts_pkg::CMD_SERVICE: begin
              ran  <= wake_pending;
              best <= (max_sleep != 0) ? max_sleep : 32'd1;
              idx  <= '0;
              state <= wake_pending ? ST_WALK : ST_OUT;
              if (!wake_pending) begin
                ob.kind <= sts_pkg::KIND_SERVICE; ob.ok <= 1'b0;
                ov <= 1'b1;
              end
            end
            sts_pkg::CMD_ADD: begin
              logic ok_add;
              logic [IW-1:0] s;
              ok_add = found || (has_free && len < CW'(SLOTS));
              s = found ? fslot : free_slot;
              if (!found && ok_add) begin
                order[len[IW-1:0]] <= free_slot;
                len <= len + 1'b1;
              end
              if (ok_add) begin
                used[s] <= 1'b1; skey[s] <= r.task_key;
                sdly[s] <= sts_pkg::sat_add({1'b0, r.delay_ms}, sleep_length - sleep_left);
                srld[s] <= {1'b0, r.reload_ms}; skil[s] <= 1'b0;
                wake_early <= 1'b1;
              end
              ob.kind <= sts_pkg::KIND_ADD; ob.ok <= ok_add;
              ov <= 1'b1; state <= ST_OUT;
            end
            sts_pkg::CMD_DELETE: begin
              if (found) begin
                skil[fslot] <= 1'b1; sdly[fslot] <= 32'd1; wake_early <= 1'b1;
              end
              ob.kind <= sts_pkg::KIND_DELETE; ob.ok <= found;
              ov <= 1'b1; state <= ST_OUT;
            end
            default: begin
              ob.kind <= sts_pkg::KIND_QUERY; ob.ok <= found;
              ov <= 1'b1; state <= ST_OUT;
            end
          endcase
        end
        // one list entry per step; due entries and the final row wait for a free result register
        ST_WALK: begin
          if (idx >= len) begin
            if (out_free) begin
              sleep_left <= best; sleep_length <= best; wake_pending <= 1'b0;
              ob.kind <= sts_pkg::KIND_SERVICE; ob.key_out <= r.task_key;
              ob.ok <= ran; ob.next_wake_ms <= best; ob.last <= 1'b1;
              ov <= 1'b1; state <= ST_OUT;
            end
          end else if (due) begin
            if (out_free) begin
              if (!skil[ws]) begin
                ob.kind <= sts_pkg::KIND_FIRED; ob.key_out <= skey[ws];
                ob.ok <= 1'b1; ob.next_wake_ms <= '0; ob.last <= 1'b0;
              end
              ov <= !skil[ws];
              if (!skil[ws] && srld[ws] != 0) begin
                sdly[ws] <= srld[ws];
                if (srld[ws] < best) best <= srld[ws];
                idx <= idx + 1'b1;
              end else begin
                used[ws] <= 1'b0; skey[ws] <= '0; sdly[ws] <= '0;
                srld[ws] <= '0; skil[ws] <= 1'b0;
                sh <= idx;
                state <= ST_SHFT;
              end
            end
          end else begin
            sdly[ws] <= diff;
            if (diff < best && diff != 0) best <= diff;
            idx <= idx + 1'b1;
          end
        end
        // close the gap in the list, one entry per cycle
        ST_SHFT: begin
          if (sh + 1'b1 < len) begin
            order[sh[IW-1:0]] <= order[IW'(sh + 1'b1)];
            sh <= sh + 1'b1;
          end else begin
            len <= len - 1'b1;
            state <= ST_WALK;
          end
        end
        ST_OUT: begin
          if (!ov || rsp.ready) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

// ----- tb/software_timer_slot_scheduler_top_tb.sv -----
// Testbench for the timer slot scheduler: drives random and directed requests,
// predicts every result row and checks them in order. Depends on sts_pkg, sts_if.
`timescale 1ns / 1ps
module software_timer_slot_scheduler_top_tb;
  localparam int NSLOT = 8;
  localparam int IDLE_LIMIT = 20000;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [31:0] cfg_wdata;

  sts_req_if req_ch ();
  sts_rsp_if rsp_ch ();

  software_timer_slot_scheduler_top #(.SLOTS(NSLOT)) dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .req(req_ch.sink), .rsp(rsp_ch.source)
  );

  // scheduler model state
  logic [31:0] max_sleep;
  logic        s_used [NSLOT];
  logic [7:0]  s_key [NSLOT];
  logic [31:0] s_delay [NSLOT];
  logic [31:0] s_reload [NSLOT];
  logic        s_kill [NSLOT];
  logic [2:0]  order [NSLOT];
  int          order_len;
  logic        wake_pend, wake_early;
  logic [31:0] sleep_len, sleep_left, banked;

  sts_pkg::req_t pending_reqs[$];
  sts_pkg::rsp_t expected_rows[$];
  int   failures;
  int   send_idle_pct, recv_idle_pct;
  int   idle_cycles;

  function automatic logic [31:0] add_clamped(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic int key_slot(logic [7:0] k);
    for (int i = 0; i < NSLOT; i++)
      if (s_used[i] && s_key[i] == k) return i;
    return -1;
  endfunction

  function automatic void push_row(logic [2:0] kd, logic [7:0] k, logic o, logic [31:0] nw);
    sts_pkg::rsp_t r;
    r.kind = kd; r.key_out = k; r.ok = o; r.next_wake_ms = nw; r.last = 1'b0;
    expected_rows.push_back(r);
  endfunction

  task automatic clear_model();
    max_sleep = sts_pkg::MAX_SLEEP_RESET;
    for (int i = 0; i < NSLOT; i++) begin
      s_used[i] = 0; s_key[i] = 0; s_delay[i] = 0; s_reload[i] = 0;
      s_kill[i] = 0; order[i] = 0;
    end
    order_len = 0; wake_pend = 1; wake_early = 0;
    sleep_len = 0; sleep_left = 0; banked = 0;
  endtask

  // Work out the rows one request causes and queue them.
  task automatic schedule_rows(sts_pkg::req_t q);
    int base, s, k;
    logic [31:0] cd, best, d;
    logic ran;
    base = expected_rows.size();
    case (q.cmd)
      sts_pkg::CMD_TICK: begin
        if (!wake_pend) begin
          cd = add_clamped({16'd0, q.elapsed_ms}, banked);
          if (sleep_len > 0) begin
            if (sleep_left > cd) sleep_left = sleep_left - cd;
            else begin
              sleep_left = 0; wake_pend = 1; wake_early = 0;
            end
            if (wake_early) begin
              sleep_len = sleep_len - sleep_left;
              sleep_left = 0; wake_pend = 1; wake_early = 0;
            end
          end
          banked = 0;
        end else banked = add_clamped(banked, {16'd0, q.elapsed_ms});
        push_row(sts_pkg::KIND_TICK, q.task_key, wake_pend, '0);
      end
      sts_pkg::CMD_SERVICE: begin
        ran = wake_pend;
        if (wake_pend) begin
          best = (max_sleep != 0) ? max_sleep : 32'd1;
          k = 0;
          while (k < order_len) begin
            s = order[k];
            if (s_delay[s] <= sleep_len) begin
              if (s_kill[s]) s_reload[s] = 0;
              else push_row(sts_pkg::KIND_FIRED, s_key[s], 1'b1, '0);
              s_delay[s] = 0;
              if (s_reload[s] > 0) s_delay[s] = s_reload[s];
              else begin
                s_used[s] = 0; s_key[s] = 0; s_delay[s] = 0;
                s_reload[s] = 0; s_kill[s] = 0;
                for (int j = k; j + 1 < order_len; j++) order[j] = order[j + 1];
                order_len--;
                continue;
              end
            end else s_delay[s] = s_delay[s] - sleep_len;
            if (s_delay[s] < best && s_delay[s] > 0) best = s_delay[s];
            k++;
          end
          sleep_left = best; sleep_len = best; wake_pend = 0;
        end
        push_row(sts_pkg::KIND_SERVICE, q.task_key, ran, sleep_len);
      end
      sts_pkg::CMD_ADD: begin
        d = add_clamped({1'b0, q.delay_ms}, sleep_len - sleep_left);
        s = key_slot(q.task_key);
        if (s < 0) begin
          for (int i = NSLOT - 1; i >= 0; i--) if (!s_used[i]) s = i;
          if (s >= 0 && order_len < NSLOT) begin
            order[order_len] = s[2:0]; order_len++;
          end else s = -1;
        end
        if (s >= 0) begin
          s_used[s] = 1; s_key[s] = q.task_key; s_delay[s] = d;
          s_reload[s] = {1'b0, q.reload_ms}; s_kill[s] = 0; wake_early = 1;
        end
        push_row(sts_pkg::KIND_ADD, q.task_key, s >= 0, '0);
      end
      sts_pkg::CMD_DELETE: begin
        s = key_slot(q.task_key);
        if (s >= 0) begin
          s_kill[s] = 1; s_delay[s] = 1; wake_early = 1;
        end
        push_row(sts_pkg::KIND_DELETE, q.task_key, s >= 0, '0);
      end
      sts_pkg::CMD_QUERY:
        push_row(sts_pkg::KIND_QUERY, q.task_key, key_slot(q.task_key) >= 0, '0);
      default: ;
    endcase
    if (expected_rows.size() > base) expected_rows[$].last = 1'b1;
  endtask

  // clock
  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  // Drive requests from the pending queue.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (req_ch.valid && req_ch.ready) void'(pending_reqs.pop_front());
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        req_ch.valid <= 1'b1;
        req_ch.payload <= pending_reqs[0];
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver stall and result check.
  always @(posedge clk) begin
    sts_pkg::rsp_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      idle_cycles <= 0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      if (req_ch.valid && req_ch.ready) schedule_rows(req_ch.payload);
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_rows.size() == 0) begin
          $display("%0t: unexpected row, expected none, actual %p", $time, rsp_ch.payload);
          failures++;
        end else begin
          want = expected_rows.pop_front();
          if (rsp_ch.payload !== want) begin
            $display("%0t: row mismatch, expected %p, actual %p",
                     $time, want, rsp_ch.payload);
            failures++;
          end
        end
      end
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  function automatic sts_pkg::req_t make_req(logic [2:0] c, logic [7:0] k, logic [30:0] d,
                                             logic [30:0] r, logic [15:0] e);
    sts_pkg::req_t q;
    q.cmd = c; q.task_key = k; q.delay_ms = d; q.reload_ms = r; q.elapsed_ms = e;
    return q;
  endfunction

  function automatic sts_pkg::req_t random_req();
    sts_pkg::req_t q;
    int pick;
    q = make_req(3'($urandom_range(4)), 8'($urandom_range(11)), 31'($urandom_range(300)),
                 31'($urandom_range(3) == 0 ? $urandom_range(200) : 0),
                 16'($urandom_range(120)));
    pick = $urandom_range(99);
    if (pick < 4) q.task_key = 8'($urandom);
    else if (pick < 8) q.delay_ms = 31'($urandom);
    else if (pick < 12) q.reload_ms = 31'($urandom);
    else if (pick < 16) q.elapsed_ms = 16'($urandom);
    else if (pick < 18) q.cmd = 3'($urandom_range(7, 5));
    return q;
  endfunction

  // Hold until everything queued has been accepted and answered.
  task automatic drain();
    while (pending_reqs.size() != 0 || req_ch.valid || expected_rows.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_max_sleep(logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    max_sleep = v;
  endtask

  initial begin
    failures = 0;
    send_idle_pct = 29; recv_idle_pct = 50;
    rst = 1'b1; cfg_we = 1'b0; cfg_wdata = '0;
    req_ch.valid = 1'b0; req_ch.payload = '0; rsp_ch.ready = 1'b0;
    clear_model();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, table full, kill, unknown command, saturation
    pending_reqs.push_back(make_req(sts_pkg::CMD_SERVICE, 8'hFF, '0, '0, '0));
    pending_reqs.push_back(make_req(sts_pkg::CMD_SERVICE, '0, '0, '0, '0));
    pending_reqs.push_back(make_req(sts_pkg::CMD_TICK, '0, '0, '0, 16'hFFFF));
    for (int i = 0; i < 9; i++)
      pending_reqs.push_back(make_req(sts_pkg::CMD_ADD, 8'(i * 31), 31'(i * 5),
                                      i[0] ? 31'h7FFF_FFFF : 31'd0, '0));
    pending_reqs.push_back(make_req(sts_pkg::CMD_DELETE, 8'd31, '0, '0, '0));
    pending_reqs.push_back(make_req(sts_pkg::CMD_DELETE, 8'd7, '0, '0, '0));
    pending_reqs.push_back(make_req(sts_pkg::CMD_QUERY, 8'd62, '0, '0, '0));
    pending_reqs.push_back(make_req(sts_pkg::CMD_QUERY, 8'd1, '0, '0, '0));
    pending_reqs.push_back(make_req(3'd7, 8'd1, 31'h7FFF_FFFF, '0, 16'hFFFF));
    pending_reqs.push_back(make_req(sts_pkg::CMD_SERVICE, '0, '0, '0, '0));
    pending_reqs.push_back(make_req(sts_pkg::CMD_TICK, '0, '0, '0, 16'd3));
    pending_reqs.push_back(make_req(sts_pkg::CMD_ADD, 8'd0, 31'h7FFF_FFFF, '0, '0));
    pending_reqs.push_back(make_req(sts_pkg::CMD_TICK, '0, '0, '0, 16'hFFFF));
    pending_reqs.push_back(make_req(sts_pkg::CMD_SERVICE, '0, '0, '0, '0));
    pending_reqs.push_back(make_req(sts_pkg::CMD_SERVICE, '0, '0, '0, '0));
    drain();

    // random phases over several register settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_max_sleep(32'd0);
        1: write_max_sleep(32'hFFFF_FFFF);
        2: begin write_max_sleep(32'd1); send_idle_pct = 50; recv_idle_pct = 29; end
        3: write_max_sleep(32'd150);
        4: begin write_max_sleep(32'd60000); send_idle_pct = 0; recv_idle_pct = 0; end
        default: write_max_sleep(32'($urandom_range(400, 2)));
      endcase
      for (int n = 0; n < 56; n++) pending_reqs.push_back(random_req());
      drain();
    end

    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// ----- files.f -----
hw/rtl/sts_pkg.sv
hw/rtl/sts_if.sv
hw/rtl/software_timer_slot_scheduler_top.sv
tb/software_timer_slot_scheduler_top_tb.sv
